[rtl/vcsp_pkg.sv]
`timescale 1ns / 1ps

package vcsp_pkg;

    localparam int KindWidth   = 3;
    localparam int TargetWidth = 2;
    localparam int ByteWidth   = 8;
    localparam int WaitWidth   = 16;

    // Result kinds
    localparam logic [KindWidth-1:0] KIND_WRITE    = 3'd0;
    localparam logic [KindWidth-1:0] KIND_WAIT     = 3'd1;
    localparam logic [KindWidth-1:0] KIND_END_LOOP = 3'd2;
    localparam logic [KindWidth-1:0] KIND_END_STOP = 3'd3;
    localparam logic [KindWidth-1:0] KIND_UNKNOWN  = 3'd4;

    // Chip targets
    localparam logic [TargetWidth-1:0] TGT_PSG  = 2'd0;
    localparam logic [TargetWidth-1:0] TGT_FM0  = 2'd1;
    localparam logic [TargetWidth-1:0] TGT_FM1  = 2'd2;

    // Command codes
    localparam logic [ByteWidth-1:0] CMD_PSG_PAIR = 8'h4F;
    localparam logic [ByteWidth-1:0] CMD_PSG      = 8'h50;
    localparam logic [ByteWidth-1:0] CMD_FM0      = 8'h52;
    localparam logic [ByteWidth-1:0] CMD_FM1      = 8'h53;
    localparam logic [ByteWidth-1:0] CMD_WAIT_N   = 8'h61;
    localparam logic [ByteWidth-1:0] CMD_WAIT_NTSC = 8'h62;
    localparam logic [ByteWidth-1:0] CMD_WAIT_PAL = 8'h63;
    localparam logic [ByteWidth-1:0] CMD_END      = 8'h66;
    localparam logic [ByteWidth-1:0] CMD_NOP_A    = 8'h67;
    localparam logic [ByteWidth-1:0] CMD_NOP_B    = 8'hE0;
    localparam logic [3:0]           GRP_SHORT_WAIT = 4'h7;
    localparam logic [3:0]           GRP_DAC_WAIT   = 4'h8;

    localparam logic [ByteWidth-1:0] PSG_PAIR_FIRST = 8'h06;
    localparam logic [WaitWidth-1:0] WAIT_NTSC      = 16'd735;
    localparam logic [WaitWidth-1:0] WAIT_PAL       = 16'd882;

    // Result queue depth
    localparam int ResDepth = 4;

    typedef struct packed {
        logic [KindWidth-1:0]   kind;
        logic [TargetWidth-1:0] chip_target;
        logic [ByteWidth-1:0]   reg_addr;
        logic [ByteWidth-1:0]   reg_data;
        logic [WaitWidth-1:0]   wait_samples;
        logic                   last_of_run;
    } result_t;

endpackage

[rtl/vcsp_if.sv]
`timescale 1ns / 1ps

interface vcsp_byte_if import vcsp_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [ByteWidth-1:0] cmd_byte;

    modport source (output valid, output cmd_byte, input ready);
    modport sink   (input valid, input cmd_byte, output ready);
endinterface

interface vcsp_result_if import vcsp_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [KindWidth-1:0]   kind;
    logic [TargetWidth-1:0] chip_target;
    logic [ByteWidth-1:0]   reg_addr;
    logic [ByteWidth-1:0]   reg_data;
    logic [WaitWidth-1:0]   wait_samples;
    logic                   last_of_run;

    modport source (output valid, output kind, output chip_target, output reg_addr,
                    output reg_data, output wait_samples, output last_of_run,
                    input ready);
    modport sink   (input valid, input kind, input chip_target, input reg_addr,
                    input reg_data, input wait_samples, input last_of_run,
                    output ready);
endinterface

interface vcsp_cfg_if;
    logic valid;
    logic ready;
    logic loop_enable;

    modport source (output valid, output loop_enable, input ready);
    modport sink   (input valid, input loop_enable, output ready);
endinterface

[rtl/vgm_command_stream_parser.sv]
`timescale 1ns / 1ps
// A result word is registered into the result queue when the byte that completes it is accepted.
// Throughput: one command byte per cycle while the result queue holds at most two entries;
// command 0x4F writes its pair of results into the four-entry result queue at once.
// Reset (rst_n low, asynchronous) clears the parse phase, halt flag, loop enable and
// the result queue; queue payload is not reset.

module vgm_command_stream_parser
    import vcsp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    vcsp_byte_if.sink        cmd_chan,
    vcsp_result_if.source    result_chan,
    vcsp_cfg_if.sink         cfg_chan
);

    localparam int PtrWidth = $clog2(ResDepth);
    localparam int CntWidth = $clog2(ResDepth + 1);
    localparam logic [CntWidth-1:0] RoomLimit = CntWidth'(ResDepth - 2);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PSG_DATA,
        PH_FM_ADDR,
        PH_FM_DATA,
        PH_WAIT_LO,
        PH_WAIT_HI
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [ByteWidth-1:0] pending_reg, pending_next;
    logic [ByteWidth-1:0] first_reg, first_next;
    logic                 halted_reg, halted_next;
    logic                 loop_en_reg;

    result_t              queue_reg [ResDepth];
    logic [PtrWidth-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CntWidth-1:0]  count_reg;

    result_t              res0, res1;
    logic [1:0]           n_res;
    logic                 accept, pop;
    logic [ByteWidth-1:0] b;

    assign b      = cmd_chan.cmd_byte;
    assign cmd_chan.ready = (count_reg <= RoomLimit);
    assign accept = cmd_chan.valid && cmd_chan.ready;
    assign pop    = result_chan.valid && result_chan.ready;
    assign cfg_chan.ready = 1'b1;

    always_comb
    begin
        phase_next   = phase_reg;
        pending_next = pending_reg;
        first_next   = first_reg;
        halted_next  = halted_reg;
        n_res        = 2'd0;
        res0         = '{kind: KIND_WAIT, chip_target: TGT_PSG, reg_addr: '0,
                         reg_data: '0, wait_samples: '0, last_of_run: 1'b1};
        res1         = res0;

        if (!halted_reg)
        begin
            case (phase_reg)
                PH_PSG_DATA:
                begin
                    phase_next = PH_IDLE;
                    res0.kind  = KIND_WRITE;
                    res0.wait_samples = WaitWidth'(1);
                    if (pending_reg == CMD_PSG_PAIR)
                    begin
                        res0.reg_data    = PSG_PAIR_FIRST;
                        res0.last_of_run = 1'b0;
                        res1.kind        = KIND_WRITE;
                        res1.reg_data    = b;
                        res1.wait_samples = WaitWidth'(1);
                        n_res            = 2'd2;
                    end
                    else
                    begin
                        res0.reg_data = b;
                        n_res         = 2'd1;
                    end
                end
                PH_FM_ADDR:
                begin
                    first_next = b;
                    phase_next = PH_FM_DATA;
                end
                PH_FM_DATA:
                begin
                    phase_next        = PH_IDLE;
                    res0.kind         = KIND_WRITE;
                    res0.chip_target  = (pending_reg == CMD_FM1) ? TGT_FM1 : TGT_FM0;
                    res0.reg_addr     = first_reg;
                    res0.reg_data     = b;
                    res0.wait_samples = WaitWidth'(1);
                    n_res             = 2'd1;
                end
                PH_WAIT_LO:
                begin
                    first_next = b;
                    phase_next = PH_WAIT_HI;
                end
                PH_WAIT_HI:
                begin
                    phase_next        = PH_IDLE;
                    res0.wait_samples = {b, first_reg};
                    n_res             = 2'd1;
                end
                default:
                begin
                    // A new command byte.
                    phase_next   = PH_IDLE;
                    pending_next = b;
                    if (b == CMD_PSG_PAIR || b == CMD_PSG)
                        phase_next = PH_PSG_DATA;
                    else if (b == CMD_FM0 || b == CMD_FM1)
                        phase_next = PH_FM_ADDR;
                    else if (b == CMD_WAIT_N)
                        phase_next = PH_WAIT_LO;
                    else if (b == CMD_WAIT_NTSC)
                    begin
                        res0.wait_samples = WAIT_NTSC;
                        n_res = 2'd1;
                    end
                    else if (b == CMD_WAIT_PAL)
                    begin
                        res0.wait_samples = WAIT_PAL;
                        n_res = 2'd1;
                    end
                    else if (b[7:4] == GRP_SHORT_WAIT)
                    begin
                        res0.wait_samples = WaitWidth'({1'b0, b[3:0]} + 5'd1);
                        n_res = 2'd1;
                    end
                    else if (b[7:4] == GRP_DAC_WAIT)
                    begin
                        res0.wait_samples = WaitWidth'(b[3:0]);
                        n_res = 2'd1;
                    end
                    else if (b == CMD_END)
                    begin
                        n_res = 2'd1;
                        if (loop_en_reg)
                            res0.kind = KIND_END_LOOP;
                        else
                        begin
                            res0.kind   = KIND_END_STOP;
                            halted_next = 1'b1;
                        end
                    end
                    else if (b != CMD_NOP_A && b != CMD_NOP_B)
                    begin
                        res0.kind     = KIND_UNKNOWN;
                        res0.reg_data = b;
                        halted_next   = 1'b1;
                        n_res         = 2'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            pending_reg <= '0;
            first_reg   <= '0;
            halted_reg  <= 1'b0;
            loop_en_reg <= 1'b0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
        end
        else
        begin
            if (cfg_chan.valid)
                loop_en_reg <= cfg_chan.loop_enable;
            if (accept)
            begin
                phase_reg   <= phase_next;
                pending_reg <= pending_next;
                first_reg   <= first_next;
                halted_reg  <= halted_next;
                wr_ptr_reg  <= wr_ptr_reg + PtrWidth'(n_res);
            end
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PtrWidth'(1);
            count_reg <= count_reg + (accept ? CntWidth'(n_res) : CntWidth'(0))
                         - (pop ? CntWidth'(1) : CntWidth'(0));
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && n_res != 2'd0)
            queue_reg[wr_ptr_reg] <= res0;
        if (accept && n_res == 2'd2)
            queue_reg[wr_ptr_reg + PtrWidth'(1)] <= res1;
    end

    assign result_chan.valid        = (count_reg != '0);
    assign result_chan.kind         = queue_reg[rd_ptr_reg].kind;
    assign result_chan.chip_target  = queue_reg[rd_ptr_reg].chip_target;
    assign result_chan.reg_addr     = queue_reg[rd_ptr_reg].reg_addr;
    assign result_chan.reg_data     = queue_reg[rd_ptr_reg].reg_data;
    assign result_chan.wait_samples = queue_reg[rd_ptr_reg].wait_samples;
    assign result_chan.last_of_run  = queue_reg[rd_ptr_reg].last_of_run;

endmodule
